// ===== design/pcxrle_pkg.sv =====
// ----------------------------------------------------------------------------
// PCX RLE decoder package
// Shared types, constants and helpers for the PCX run-length decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    // Width of the internal buffer address; it wraps at 2**ADDR_BITS.
    localparam int ADDR_BITS = 24;

    localparam logic [7:0]  RUN_MARK = 8'hC0;
    localparam logic [5:0]  RUN_MASK = 6'h3F;
    localparam logic [16:0] CNT_MAX  = 17'h1FFFF;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_PADDING = 2'd2;

    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       start_of_image;
    } in_t;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [23:0] pixel_address;
        logic        last_of_run;
        logic        image_done;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic step;     // emit the next pixel of a run
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic emits;    // the offered byte gives at least one pixel
        logic multi;    // the offered byte gives more than one pixel
        logic rem_last; // the run has one pixel left
    } status_t;

    // Show the buffer address in its low 24 bits.
    function automatic logic [23:0] addr_view(addr_t a);
        logic [31:0] w;
        w = 32'(a);
        return w[23:0];
    endfunction

endpackage

// ===== design/pcxrle_ctrl.sv =====
// ----------------------------------------------------------------------------
// PCX RLE decoder controller
// Sequences input transfers and run expansion; owns the output valid flag.
// ----------------------------------------------------------------------------
module pcxrle_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  pcxrle_pkg::status_t status,
    output pcxrle_pkg::cmd_t    cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.accept = in_valid && !in_stall;
        cmd.step   = (state_reg == ST_EMIT) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.multi)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.step && status.rem_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if ((cmd.accept && status.emits) || cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/pcxrle_dpath.sv =====
// ----------------------------------------------------------------------------
// PCX RLE decoder datapath
// Configuration, decode state, run register and the output pixel register.
// ----------------------------------------------------------------------------
module pcxrle_dpath
(
    input  logic                clk,
    input  logic                rst_n,
    input  pcxrle_pkg::in_t     in_data,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    input  pcxrle_pkg::cmd_t    cmd,
    output pcxrle_pkg::status_t status,
    output pcxrle_pkg::out_t    out_data
);

    // Configuration
    logic [16:0] width_reg;
    logic [16:0] height_reg;
    logic [15:0] pad_reg;

    // Decode state
    logic              pend_reg;
    logic [5:0]        rl_reg;
    logic [16:0]       col_reg;
    logic [16:0]       row_reg;
    pcxrle_pkg::addr_t addr_reg;
    logic              fin_reg;

    // Run in progress
    logic [7:0]        pix_reg;
    logic [5:0]        rem_reg;
    logic              row_end_reg;
    logic              done_reg;
    pcxrle_pkg::out_t  out_reg;

    // Byte decode
    logic              clr;
    logic              pend_e;
    logic [5:0]        rl_e;
    logic [16:0]       col_e;
    logic [16:0]       row_e;
    pcxrle_pkg::addr_t addr_e;
    logic              fin_e;
    logic              ignore;
    logic              is_mark;
    logic              gives;
    logic [5:0]        count;
    logic [17:0]       col_sum;
    logic [16:0]       col_after;
    logic              row_end;
    logic [16:0]       row_inc;
    logic              done;
    pcxrle_pkg::addr_t pad_acc;
    pcxrle_pkg::addr_t pad_step;

    // A start flag clears the image state before the byte is handled.
    assign clr    = in_data.start_of_image;
    assign pend_e = clr ? 1'b0  : pend_reg;
    assign rl_e   = clr ? 6'd0  : rl_reg;
    assign col_e  = clr ? 17'd0 : col_reg;
    assign row_e  = clr ? 17'd0 : row_reg;
    assign addr_e = clr ? '0    : addr_reg;
    assign fin_e  = clr ? 1'b0  : fin_reg;

    assign ignore  = fin_e || (row_e >= height_reg);
    assign is_mark = in_data.code_byte >= pcxrle_pkg::RUN_MARK;
    assign gives   = !ignore && (pend_e || !is_mark);
    assign count   = pend_e ? rl_e : 6'd1;

    // Column count saturates at its maximum.
    assign col_sum   = {1'b0, col_e} + 18'(count);
    assign col_after = col_sum[17] ? pcxrle_pkg::CNT_MAX : col_sum[16:0];
    assign row_end   = col_after >= width_reg;
    assign row_inc   = row_e + 17'd1;
    assign done      = row_end && (row_inc >= height_reg);

    assign pad_acc  = row_end ? pcxrle_pkg::addr_t'(pad_reg) : '0;
    assign pad_step = (row_end_reg && (rem_reg == 6'd1)) ?
                      pcxrle_pkg::addr_t'(pad_reg) : '0;

    always_comb
    begin
        status.emits    = gives && (count != 6'd0);
        status.multi    = gives && (count > 6'd1);
        status.rem_last = rem_reg == 6'd1;
    end

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 17'd1;
            height_reg <= 17'd1;
            pad_reg    <= 16'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pcxrle_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                pcxrle_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                pcxrle_pkg::CFG_LINE_PADDING: pad_reg    <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            rl_reg   <= 6'd0;
            col_reg  <= 17'd0;
            row_reg  <= 17'd0;
            addr_reg <= '0;
            fin_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (gives)
            begin
                pend_reg <= 1'b0;
                rl_reg   <= rl_e;
                col_reg  <= row_end ? 17'd0 : col_after;
                row_reg  <= row_end ? row_inc : row_e;
                fin_reg  <= row_end ? done : fin_e;
                if (count == 6'd0)
                begin
                    addr_reg <= addr_e + pad_acc;
                end
                else if (count == 6'd1)
                begin
                    addr_reg <= addr_e + pcxrle_pkg::addr_t'(1) + pad_acc;
                end
                else
                begin
                    addr_reg <= addr_e + pcxrle_pkg::addr_t'(1);
                end
            end
            else if (!ignore)
            begin
                // count byte: hold the run length for the next byte
                pend_reg <= 1'b1;
                rl_reg   <= in_data.code_byte[5:0] & pcxrle_pkg::RUN_MASK;
                col_reg  <= col_e;
                row_reg  <= row_e;
                addr_reg <= addr_e;
                fin_reg  <= fin_e;
            end
            else
            begin
                pend_reg <= pend_e;
                rl_reg   <= rl_e;
                col_reg  <= col_e;
                row_reg  <= row_e;
                addr_reg <= addr_e;
                fin_reg  <= fin_e;
            end
        end
        else if (cmd.step)
        begin
            addr_reg <= addr_reg + pcxrle_pkg::addr_t'(1) + pad_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg     <= in_data.code_byte;
            rem_reg     <= count - 6'd1;
            row_end_reg <= row_end;
            done_reg    <= done;
            if (status.emits)
            begin
                out_reg.pixel_value   <= in_data.code_byte;
                out_reg.pixel_address <= pcxrle_pkg::addr_view(addr_e);
                out_reg.last_of_run   <= count == 6'd1;
                out_reg.image_done    <= done;
            end
        end
        else if (cmd.step)
        begin
            rem_reg               <= rem_reg - 6'd1;
            out_reg.pixel_value   <= pix_reg;
            out_reg.pixel_address <= pcxrle_pkg::addr_view(addr_reg);
            out_reg.last_of_run   <= rem_reg == 6'd1;
            out_reg.image_done    <= done_reg;
        end
    end

endmodule

// ===== design/pcx_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// PCX RLE decoder
// Expands a PCX run-length byte stream into addressed pixels.
// ----------------------------------------------------------------------------
// One compressed byte is taken per input transfer. A literal byte yields one
// pixel, presented in the output register the cycle after its transfer, so
// literals stream at one byte per clock while out_stall is low. A count byte
// (0xC0 and above) yields nothing; the data byte that follows it yields n
// pixels (n from 0 to 63), one per cycle while out_stall is low, starting
// the cycle after its transfer; input is stalled while the rest of the run
// is emitted from the single output pixel register. The next byte
// can be taken in the same cycle that the held pixel is transferred; while a
// pixel is held by out_stall, input is stalled too. Each pixel carries its
// buffer address; at a row end the address skips line_padding bytes. After
// the last row, bytes are dropped until one arrives with start_of_image set.
// Write configuration only while the block is idle; cfg_ready is always high.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module pcx_rle_decoder
(
    input  logic             clk,
    input  logic             rst_n,
    // compressed byte channel
    input  logic             in_valid,
    output logic             in_stall,
    input  pcxrle_pkg::in_t  in_data,
    // pixel channel
    output logic             out_valid,
    input  logic             out_stall,
    output pcxrle_pkg::out_t out_data,
    // configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [16:0]      cfg_data
);

    pcxrle_pkg::cmd_t    cmd;
    pcxrle_pkg::status_t status;

    // Registers take writes on any cycle.
    assign cfg_ready = 1'b1;

    pcxrle_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pcxrle_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    // Take a byte only when the output register is free or being drained.
    a_accept_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (!out_valid || !out_stall))
        else $error("input taken while output register is blocked");

    // A pixel that is not the last of its run is followed at once by the next.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_data.last_of_run) |=> out_valid)
        else $error("run expansion broke off early");

    // All pixels of one run carry the same completion flag.
    a_done_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_data.last_of_run) |=>
        (out_data.image_done == $past(out_data.image_done)))
        else $error("image_done changed within a run");

endmodule
